// ===== sv/bucketed_hash_table_assert.svh =====
// Assertion macros for the hash table block
`ifndef BUCKETED_HASH_TABLE_ASSERT_SVH
`define BUCKETED_HASH_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BHT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BHT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BHT_ASSERT_IMP(label, clk, rst, ante, cons)
`define BHT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/bht_pkg.sv =====
package bht_pkg;
   localparam int unsigned KEY_W   = 64;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned HASH_W  = 32;
   localparam logic [HASH_W-1:0] DJB2_SEED = 32'd5381;

   localparam logic [1:0] ACT_GET = 2'd0;
   localparam logic [1:0] ACT_PUT = 2'd1;
   localparam logic [1:0] ACT_DEL = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key_in;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] value_out;
   } rsp_type;

   // hashed request handed from front to back
   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [HASH_W-1:0]  hash;
   } job_type;
endpackage

// ===== sv/bht_if.sv =====
interface bht_req_if;
   import bht_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bht_rsp_if;
   import bht_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bht_front.sv =====
`include "bucketed_hash_table_assert.svh"
// Masks the key and value, hashes one key byte a cycle.
module bht_front #(
   parameter int unsigned KEY_BYTES   = 8,
   parameter int unsigned VALUE_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   bht_req_if.sink          req,
   output logic             job_valid,
   input  logic             job_ready,
   output bht_pkg::job_type job
);
   import bht_pkg::*;

   localparam int unsigned CNT_W = $clog2(KEY_BYTES + 1);

   typedef enum logic [1:0] {S_IDLE, S_HASH, S_OUT} state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   job_type            job_ff;
   logic [KEY_W-1:0]   kmask;
   logic [VALUE_W-1:0] vmask;
   logic [7:0]         cur_byte;

   always_comb begin
      kmask = '0;
      vmask = '0;
      for (int i = 0; i < KEY_BYTES; i++) kmask[i*8 +: 8] = 8'hFF;
      for (int i = 0; i < VALUE_BYTES; i++) vmask[i*8 +: 8] = 8'hFF;
   end

   assign cur_byte  = job_ff.key[cnt_ff[CNT_W-1:0]*8 +: 8];
   assign req.ready = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_OUT);
   assign job       = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  job_ff.action <= req.data.action;
                  job_ff.key    <= req.data.key_in & kmask;
                  job_ff.value  <= req.data.value_in & vmask;
                  job_ff.hash   <= DJB2_SEED;
                  cnt_ff        <= '0;
                  state_ff      <= S_HASH;
               end
            end
            S_HASH: begin
               job_ff.hash <= (job_ff.hash << 5) + job_ff.hash + {24'd0, cur_byte};
               cnt_ff      <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(KEY_BYTES - 1)) state_ff <= S_OUT;
            end
            S_OUT: if (job_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BHT_ASSERT_NXT(a_hash_len, clock, reset, state_ff == S_IDLE && req.valid, state_ff == S_HASH && cnt_ff == '0)
   `BHT_ASSERT_IMP(a_cnt_range, clock, reset, state_ff == S_HASH, cnt_ff < CNT_W'(KEY_BYTES))
   `BHT_ASSERT_NXT(a_out_hold, clock, reset, job_valid && !job_ready, job_valid && $stable(job_ff))
endmodule

// ===== sv/bht_queue.sv =====
`include "bucketed_hash_table_assert.svh"
// Two-entry queue between front and back.
module bht_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bht_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output bht_pkg::job_type out_job
);
   import bht_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   `BHT_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `BHT_ASSERT_IMP(a_ptr_match, clock, reset, cnt_ff == 2'd0 || cnt_ff == 2'd2, wp_ff == rp_ff)
   `BHT_ASSERT_IMP(a_ptr_one, clock, reset, cnt_ff == 2'd1, wp_ff != rp_ff)
endmodule

// ===== sv/bht_back.sv =====
`include "bucketed_hash_table_assert.svh"
// Scans one bucket slot by slot and applies get, put or delete.
module bht_back #(
   parameter int unsigned BUCKETS = 512,
   parameter int unsigned SLOTS   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  bht_pkg::job_type job,
   bht_rsp_if.source        rsp
);
   import bht_pkg::*;

   localparam int unsigned BK_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned FILL_W = $clog2(SLOTS + 1);
   localparam int unsigned TOTAL  = BUCKETS * SLOTS;
   localparam int unsigned AD_W   = $clog2(TOTAL);
   // hash / BUCKETS = (hash * RECIP) >> (HASH_W + RL), exact for any 32-bit hash
   localparam int unsigned RL     = $clog2(BUCKETS);
   localparam logic [63:0] RECIP  =
      ((64'd1 << (HASH_W + RL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_QUO, S_MOD, S_CLRR, S_CLR, S_FILL, S_RD, S_CMP,
      S_MVRD, S_MVWR, S_RSP
   } state_type;

   // slot store: hash, key and data in one word
   localparam int unsigned SW = HASH_W + KEY_W + VALUE_W;
   logic [SW-1:0]     slot_mem [TOTAL];
   logic [FILL_W-1:0] fill_mem [BUCKETS];

   state_type         state_ff;
   job_type           job_ff;
   logic [48:0]       plo_ff;
   logic [47:0]       phi_ff;
   logic [HASH_W-1:0] quo_ff;
   logic [BK_W-1:0]   bkt_ff;
   logic [BK_W:0]     clr_ff;
   logic [FILL_W-1:0] fill_ff, idx_ff, hit_ff;
   logic [SW-1:0]     rd_ff;
   logic [FILL_W-1:0] fill_rd_ff;
   rsp_type           res_ff;
   rsp_type           rsp_ff;
   logic              rsp_v_ff;

   logic [65:0]       prod;
   logic [HASH_W-1:0] rem_c;
   logic [AD_W-1:0]   addr;
   logic              match;

   assign prod   = 66'({phi_ff, 17'd0}) + 66'(plo_ff);
   assign rem_c  = job_ff.hash - quo_ff * HASH_W'(BUCKETS);
   assign match  = rd_ff[SW-1 -: HASH_W] == job_ff.hash
                && rd_ff[VALUE_W +: KEY_W] == job_ff.key;
   assign job_ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;

   function automatic logic [AD_W-1:0] slot_addr(logic [BK_W-1:0] b, logic [FILL_W-1:0] s);
      slot_addr = AD_W'(b) * AD_W'(SLOTS) + AD_W'(s);
   endfunction

   assign addr = slot_addr(bkt_ff, idx_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) fill_mem[clr_ff[BK_W-1:0]] <= '0;
      else if (state_ff == S_RSP && !rsp_v_ff) fill_mem[bkt_ff] <= fill_ff;
      fill_rd_ff <= fill_mem[bkt_ff];
      rd_ff <= slot_mem[addr];
      if (state_ff == S_CMP && job_ff.action == ACT_PUT && (match && idx_ff < fill_ff))
         slot_mem[addr] <= {job_ff.hash, job_ff.key, job_ff.value};
      else if (state_ff == S_CMP && job_ff.action == ACT_PUT && idx_ff >= fill_ff
               && fill_ff < FILL_W'(SLOTS))
         slot_mem[addr] <= {job_ff.hash, job_ff.key, job_ff.value};
      else if (state_ff == S_MVWR)
         slot_mem[slot_addr(bkt_ff, hit_ff)] <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLRR;
         clr_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            S_CLRR: state_ff <= S_CLR;
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (BK_W+1)'(BUCKETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (job_valid) begin
               job_ff   <= job;
               state_ff <= S_MUL0;
            end
            // bucket = hash mod BUCKETS by reciprocal multiplication
            S_MUL0: begin
               plo_ff   <= 49'(job_ff.hash) * 49'(RECIP[16:0]);
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               phi_ff   <= 48'(job_ff.hash) * 48'(RECIP[32:17]);
               state_ff <= S_QUO;
            end
            S_QUO: begin
               quo_ff   <= HASH_W'(prod >> (HASH_W + RL));
               state_ff <= S_MOD;
            end
            S_MOD: begin
               bkt_ff   <= rem_c[BK_W-1:0];
               state_ff <= S_FILL;
            end
            // fill count of the new bucket is read during this cycle
            S_FILL: begin
               idx_ff   <= '0;
               state_ff <= S_RD;
            end
            S_RD: begin
               fill_ff  <= fill_rd_ff;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (idx_ff < fill_ff && !match) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end else if (idx_ff < fill_ff) begin
                  unique case (job_ff.action)
                     ACT_GET: begin
                        res_ff.status    <= ST_OK;
                        res_ff.value_out <= rd_ff[VALUE_W-1:0];
                        state_ff         <= S_RSP;
                     end
                     ACT_PUT: begin
                        res_ff.status    <= ST_OK;
                        res_ff.value_out <= '0;
                        state_ff         <= S_RSP;
                     end
                     ACT_DEL: begin
                        res_ff.status    <= ST_OK;
                        res_ff.value_out <= '0;
                        hit_ff           <= idx_ff;
                        idx_ff           <= fill_ff - 1'b1;
                        fill_ff          <= fill_ff - 1'b1;
                        state_ff         <= S_MVRD;
                     end
                     default: begin
                        res_ff.status    <= ST_NOTFOUND;
                        res_ff.value_out <= '0;
                        state_ff         <= S_RSP;
                     end
                  endcase
               end else begin
                  res_ff.value_out <= '0;
                  state_ff         <= S_RSP;
                  priority if (job_ff.action == ACT_PUT && fill_ff < FILL_W'(SLOTS)) begin
                     res_ff.status <= ST_OK;
                     fill_ff       <= fill_ff + 1'b1;
                  end else if (job_ff.action == ACT_PUT) begin
                     res_ff.status <= ST_FULL;
                  end else begin
                     res_ff.status <= ST_NOTFOUND;
                  end
               end
            end
            S_MVRD: state_ff <= S_MVWR;
            S_MVWR: state_ff <= S_RSP;
            S_RSP: if (!rsp_v_ff) begin
               rsp_ff   <= res_ff;
               rsp_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BHT_ASSERT_IMP(a_idx_bound, clock, reset, state_ff == S_CMP, idx_ff <= fill_ff)
   `BHT_ASSERT_IMP(a_fill_bound, clock, reset, state_ff == S_CMP, fill_ff <= FILL_W'(SLOTS))
   `BHT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_v_ff && !rsp.ready, rsp_v_ff && $stable(rsp_ff))
endmodule

// ===== sv/bucketed_hash_table.sv =====
// Bucketed djb2 key/value table, one get, put or delete request at a time.
// The front hashes one key byte a cycle, a two-word queue follows, and the
// back reduces the hash modulo BUCKETS by reciprocal multiplication, then
// reads the bucket slot by slot (up to SLOTS slots plus one); a delete then
// moves the last entry of the bucket into the freed slot. Hashing of the next
// request overlaps the back's work. After reset the back clears the fill
// counts, one bucket a cycle, before taking requests.
module bucketed_hash_table #(
   parameter int unsigned BUCKETS     = 512,
   parameter int unsigned SLOTS       = 8,
   parameter int unsigned KEY_BYTES   = 8,
   parameter int unsigned VALUE_BYTES = 8
) (
   input logic       clock,
   input logic       reset,
   bht_req_if.sink   req,
   bht_rsp_if.source rsp
);
   import bht_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   bht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_front (
      .clock, .reset, .req, .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   bht_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   bht_back #(.BUCKETS(BUCKETS), .SLOTS(SLOTS)) u_back (
      .clock, .reset, .job_valid(q_valid), .job_ready(q_ready), .job(q_job), .rsp
   );
endmodule
